@@ rtl/tpa_pkg.sv @@
// Shared widths, stage counts and codes for the triangle perimeter and area block.
package tpa_pkg;

   // Input coordinates and derived operands
   localparam int COORD_W     = 16;
   localparam int DIFF_W      = COORD_W + 1;
   localparam int MAG_W       = COORD_W;
   localparam int SIDE_SQ_W   = 2 * MAG_W + 1;
   localparam int VTX_SQ_W    = 2 * MAG_W;
   localparam int PROD_W      = 2 * DIFF_W;
   localparam int CROSS_W     = PROD_W + 1;

   // Result fields
   localparam int PERIM_W     = 19;
   localparam int AREA_W      = 34;

   // Stream payloads
   localparam int REQ_DATA_W  = 6 * COORD_W;
   localparam int RSP_FIELD_W = PERIM_W + AREA_W + 1;
   localparam int RSP_DATA_W  = ((RSP_FIELD_W + 7) / 8) * 8;
   localparam int RSP_PAD_W   = RSP_DATA_W - RSP_FIELD_W;

   // Pipelined square root: two radicand bits and one result bit per iteration
   localparam int SQRT_ITERS  = (SIDE_SQ_W + 1) / 2;
   localparam int SQRT_STEPS  = 2;
   localparam int SQRT_STAGES = (SQRT_ITERS + SQRT_STEPS - 1) / SQRT_STEPS;
   localparam int RAD_W       = 2 * SQRT_ITERS;
   localparam int ROOT_W      = SQRT_ITERS;
   localparam int REM_W       = ROOT_W + 3;

   // Whole pipeline: front, squares, root stages, output
   localparam int PIPE_DEPTH  = SQRT_STAGES + 3;
   localparam int STG_FRONT   = 0;
   localparam int STG_SQUARE  = 1;
   localparam int STG_ROOT    = 2;
   localparam int STG_OUT     = PIPE_DEPTH - 1;
   localparam int CNT_W       = $clog2(PIPE_DEPTH + 1);

   // Register file
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;
   localparam logic [CSR_ADDR_W-3:0] REG_RADIUS = 1'b0;

endpackage

@@ rtl/tpa_sqrt.sv @@
// Pipelined floor square root, a fixed number of digit iterations per stage.
module tpa_sqrt (
   input  logic                                clock,
   input  logic [tpa_pkg::SQRT_STAGES-1:0]     stage_en,
   input  logic [tpa_pkg::RAD_W-1:0]           radicand,
   output logic [tpa_pkg::ROOT_W-1:0]          root
);

   logic [tpa_pkg::REM_W-1:0]  rem_ff   [tpa_pkg::SQRT_STAGES];
   logic [tpa_pkg::REM_W-1:0]  rem_in   [tpa_pkg::SQRT_STAGES];
   logic [tpa_pkg::ROOT_W-1:0] root_ff  [tpa_pkg::SQRT_STAGES];
   logic [tpa_pkg::ROOT_W-1:0] root_in  [tpa_pkg::SQRT_STAGES];
   logic [tpa_pkg::RAD_W-1:0]  opnd_ff  [tpa_pkg::SQRT_STAGES];
   logic [tpa_pkg::RAD_W-1:0]  opnd_in  [tpa_pkg::SQRT_STAGES];
   logic [tpa_pkg::REM_W-1:0]  rem_src  [tpa_pkg::SQRT_STAGES];
   logic [tpa_pkg::ROOT_W-1:0] root_src [tpa_pkg::SQRT_STAGES];
   logic [tpa_pkg::RAD_W-1:0]  opnd_src [tpa_pkg::SQRT_STAGES];

   for (genvar s = 0; s < tpa_pkg::SQRT_STAGES; s++) begin : g_stage
      // Pick up the partial result of the stage before, or a fresh radicand
      if (s == 0) begin : g_first
         assign rem_src[s]  = '0;
         assign root_src[s] = '0;
         assign opnd_src[s] = radicand;
      end else begin : g_next
         assign rem_src[s]  = rem_ff[s-1];
         assign root_src[s] = root_ff[s-1];
         assign opnd_src[s] = opnd_ff[s-1];
      end

      // Run this stage's digit iterations: bring down two bits, try to subtract
      always_comb begin
         logic [tpa_pkg::REM_W-1:0]  rem_v;
         logic [tpa_pkg::ROOT_W-1:0] root_v;
         logic [tpa_pkg::RAD_W-1:0]  opnd_v;
         logic [tpa_pkg::REM_W-1:0]  trial;
         rem_v  = rem_src[s];
         root_v = root_src[s];
         opnd_v = opnd_src[s];
         trial  = '0;
         for (int k = 0; k < tpa_pkg::SQRT_STEPS; k++) begin
            if (s * tpa_pkg::SQRT_STEPS + k < tpa_pkg::SQRT_ITERS) begin
               rem_v  = {rem_v[tpa_pkg::REM_W-3:0], opnd_v[tpa_pkg::RAD_W-1 -: 2]};
               opnd_v = {opnd_v[tpa_pkg::RAD_W-3:0], 2'b00};
               trial  = tpa_pkg::REM_W'({root_v, 2'b01});
               if (rem_v >= trial) begin
                  rem_v  = rem_v - trial;
                  root_v = {root_v[tpa_pkg::ROOT_W-2:0], 1'b1};
               end else begin
                  root_v = {root_v[tpa_pkg::ROOT_W-2:0], 1'b0};
               end
            end
         end
         rem_in[s]  = rem_v;
         root_in[s] = root_v;
         opnd_in[s] = opnd_v;
      end

      // Advance when the pipeline control lets this stage load
      always_ff @(posedge clock) begin
         if (stage_en[s]) begin
            rem_ff[s]  <= rem_in[s];
            root_ff[s] <= root_in[s];
            opnd_ff[s] <= opnd_in[s];
         end
      end
   end

   assign root = root_ff[tpa_pkg::SQRT_STAGES-1];

endmodule

@@ rtl/triangle_perimeter_area.sv @@
// Top level: triangle perimeter, doubled area and containment test, fully pipelined.
//
//   channel   direction  handshake             payload
//   req_      in         req_tvalid/tready     six signed Q8.8 vertex coordinates
//   rsp_      out        rsp_tvalid/tready     perimeter, doubled area, inside flag
//   csr_      in/out     APB, pready high      radius (unsigned Q8.8) at address 0
//
// One item enters per cycle unless a stalled result holds the input; the
// tpa_pkg::PIPE_DEPTH stages are mostly square root stages of two digit iterations.
// Reset clears the valid bits and the radius register; payload registers are not reset.
// Each stage loads when it is empty or its successor moves on, so a stalled result
// holds while empty stages behind it keep filling.
module triangle_perimeter_area (
   input  logic                                clock,
   input  logic                                reset,
   // x_first, y_first, x_second, y_second, x_third, y_third (lowest bits first)
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [tpa_pkg::REQ_DATA_W-1:0]      req_tdata,
   // perimeter, area_doubled, inside_circle, zero fill (lowest bits first)
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [tpa_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [tpa_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [tpa_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [tpa_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready
);

   localparam int NS = tpa_pkg::SQRT_STAGES;

   // Configuration register
   logic [tpa_pkg::COORD_W-1:0] radius_ff;
   logic                        csr_write;

   // Pipeline control
   logic [tpa_pkg::PIPE_DEPTH-1:0] valid_ff;
   logic [tpa_pkg::PIPE_DEPTH-1:0] valid_in;
   logic [tpa_pkg::PIPE_DEPTH-1:0] move;

   // Front stage: differences and magnitudes
   logic signed [tpa_pkg::COORD_W-1:0] vx [3];
   logic signed [tpa_pkg::COORD_W-1:0] vy [3];
   logic signed [tpa_pkg::DIFF_W-1:0]  sdx [3];
   logic signed [tpa_pkg::DIFF_W-1:0]  sdy [3];
   logic [tpa_pkg::MAG_W-1:0]          side_dx_ff [3];
   logic [tpa_pkg::MAG_W-1:0]          side_dy_ff [3];
   logic [tpa_pkg::MAG_W-1:0]          vtx_ax_ff  [3];
   logic [tpa_pkg::MAG_W-1:0]          vtx_ay_ff  [3];
   logic signed [tpa_pkg::DIFF_W-1:0]  ux_ff, uy_ff, wx_ff, wy_ff;

   // Square stage
   logic [tpa_pkg::SIDE_SQ_W-1:0]      side_sq_ff [3];
   logic [tpa_pkg::VTX_SQ_W-1:0]       vtx_sq_ff  [3];
   logic [tpa_pkg::VTX_SQ_W-1:0]       rad_sq_ff;
   logic signed [tpa_pkg::PROD_W-1:0]  prod_a_ff, prod_b_ff;

   // Root stages: area and flag travel beside the roots
   logic signed [tpa_pkg::CROSS_W-1:0] cross_diff;
   logic [tpa_pkg::AREA_W-1:0]         area_in;
   logic                               inside_in;
   logic [tpa_pkg::AREA_W-1:0]         area_dl_ff   [NS];
   logic                               inside_dl_ff [NS];
   logic [tpa_pkg::ROOT_W-1:0]         root [3];

   // Output stage
   logic [tpa_pkg::PERIM_W-1:0]        perim_ff;
   logic [tpa_pkg::AREA_W-1:0]         area_ff;
   logic                               inside_ff;

   // Register write and read
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= '0;
      end else if (csr_write && csr_paddr[tpa_pkg::CSR_ADDR_W-1:2] == tpa_pkg::REG_RADIUS) begin
         radius_ff <= csr_pwdata[tpa_pkg::COORD_W-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[tpa_pkg::CSR_ADDR_W-1:2] == tpa_pkg::REG_RADIUS) begin
         csr_prdata = tpa_pkg::CSR_DATA_W'(radius_ff);
      end
   end

   // Stage loads: empty or the next stage takes its item
   always_comb begin
      move[tpa_pkg::STG_OUT] = !valid_ff[tpa_pkg::STG_OUT] || rsp_tready;
      for (int s = tpa_pkg::STG_OUT - 1; s >= 0; s--) begin
         move[s] = !valid_ff[s] || move[s+1];
      end
   end

   assign valid_in   = {valid_ff[tpa_pkg::PIPE_DEPTH-2:0], req_tvalid};
   assign req_tready = move[tpa_pkg::STG_FRONT];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int s = 0; s < tpa_pkg::PIPE_DEPTH; s++) begin
            if (move[s]) begin
               valid_ff[s] <= valid_in[s];
            end
         end
      end
   end

   // Unpack vertices and form side differences
   always_comb begin
      for (int v = 0; v < 3; v++) begin
         vx[v] = req_tdata[(2*v)*tpa_pkg::COORD_W +: tpa_pkg::COORD_W];
         vy[v] = req_tdata[(2*v+1)*tpa_pkg::COORD_W +: tpa_pkg::COORD_W];
      end
      // sides: first-third, second-third, first-second
      sdx[0] = tpa_pkg::DIFF_W'(vx[0]) - tpa_pkg::DIFF_W'(vx[2]);
      sdy[0] = tpa_pkg::DIFF_W'(vy[0]) - tpa_pkg::DIFF_W'(vy[2]);
      sdx[1] = tpa_pkg::DIFF_W'(vx[1]) - tpa_pkg::DIFF_W'(vx[2]);
      sdy[1] = tpa_pkg::DIFF_W'(vy[1]) - tpa_pkg::DIFF_W'(vy[2]);
      sdx[2] = tpa_pkg::DIFF_W'(vx[0]) - tpa_pkg::DIFF_W'(vx[1]);
      sdy[2] = tpa_pkg::DIFF_W'(vy[0]) - tpa_pkg::DIFF_W'(vy[1]);
   end

   always_ff @(posedge clock) begin
      if (move[tpa_pkg::STG_FRONT]) begin
         for (int i = 0; i < 3; i++) begin
            side_dx_ff[i] <= tpa_pkg::MAG_W'(sdx[i][tpa_pkg::DIFF_W-1] ? -sdx[i] : sdx[i]);
            side_dy_ff[i] <= tpa_pkg::MAG_W'(sdy[i][tpa_pkg::DIFF_W-1] ? -sdy[i] : sdy[i]);
            vtx_ax_ff[i]  <= vx[i][tpa_pkg::COORD_W-1] ? tpa_pkg::MAG_W'(-vx[i])
                                                       : tpa_pkg::MAG_W'(vx[i]);
            vtx_ay_ff[i]  <= vy[i][tpa_pkg::COORD_W-1] ? tpa_pkg::MAG_W'(-vy[i])
                                                       : tpa_pkg::MAG_W'(vy[i]);
         end
         ux_ff <= -sdx[2];
         uy_ff <= -sdy[0];
         wx_ff <= -sdx[0];
         wy_ff <= -sdy[2];
      end
   end

   // Square the sides, the vertices and the radius; form the cross products
   always_ff @(posedge clock) begin
      if (move[tpa_pkg::STG_SQUARE]) begin
         for (int i = 0; i < 3; i++) begin
            side_sq_ff[i] <= tpa_pkg::SIDE_SQ_W'(side_dx_ff[i]) * tpa_pkg::SIDE_SQ_W'(side_dx_ff[i])
                           + tpa_pkg::SIDE_SQ_W'(side_dy_ff[i]) * tpa_pkg::SIDE_SQ_W'(side_dy_ff[i]);
            vtx_sq_ff[i]  <= tpa_pkg::VTX_SQ_W'(vtx_ax_ff[i]) * tpa_pkg::VTX_SQ_W'(vtx_ax_ff[i])
                           + tpa_pkg::VTX_SQ_W'(vtx_ay_ff[i]) * tpa_pkg::VTX_SQ_W'(vtx_ay_ff[i]);
         end
         rad_sq_ff <= tpa_pkg::VTX_SQ_W'(radius_ff) * tpa_pkg::VTX_SQ_W'(radius_ff);
         prod_a_ff <= tpa_pkg::PROD_W'(ux_ff) * tpa_pkg::PROD_W'(uy_ff);
         prod_b_ff <= tpa_pkg::PROD_W'(wx_ff) * tpa_pkg::PROD_W'(wy_ff);
      end
   end

   // Side lengths
   for (genvar i = 0; i < 3; i++) begin : g_side
      tpa_sqrt u_sqrt (
         .clock    (clock),
         .stage_en (move[tpa_pkg::STG_ROOT +: NS]),
         .radicand (tpa_pkg::RAD_W'(side_sq_ff[i])),
         .root     (root[i])
      );
   end

   // Area magnitude and containment test, then delay them beside the roots
   assign cross_diff = tpa_pkg::CROSS_W'(prod_a_ff) - tpa_pkg::CROSS_W'(prod_b_ff);
   assign area_in    = tpa_pkg::AREA_W'(cross_diff[tpa_pkg::CROSS_W-1] ? -cross_diff
                                                                      : cross_diff);
   assign inside_in  = (vtx_sq_ff[0] <= rad_sq_ff) && (vtx_sq_ff[1] <= rad_sq_ff)
                    && (vtx_sq_ff[2] <= rad_sq_ff);

   always_ff @(posedge clock) begin
      for (int k = 0; k < NS; k++) begin
         if (move[tpa_pkg::STG_ROOT + k]) begin
            if (k == 0) begin
               area_dl_ff[k]   <= area_in;
               inside_dl_ff[k] <= inside_in;
            end else begin
               area_dl_ff[k]   <= area_dl_ff[k-1];
               inside_dl_ff[k] <= inside_dl_ff[k-1];
            end
         end
      end
   end

   // Sum the sides into the output register beside the delayed area and flag
   always_ff @(posedge clock) begin
      if (move[tpa_pkg::STG_OUT]) begin
         perim_ff  <= tpa_pkg::PERIM_W'(root[0]) + tpa_pkg::PERIM_W'(root[1])
                    + tpa_pkg::PERIM_W'(root[2]);
         area_ff   <= area_dl_ff[NS-1];
         inside_ff <= inside_dl_ff[NS-1];
      end
   end

   assign rsp_tvalid = valid_ff[tpa_pkg::STG_OUT];
   assign rsp_tdata  = {{tpa_pkg::RSP_PAD_W{1'b0}}, inside_ff, area_ff, perim_ff};

endmodule

@@ rtl/tpa_checker.sv @@
// Port-level checks on the triangle block, bound to its top level.
module tpa_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [tpa_pkg::RSP_DATA_W-1:0]      rsp_tdata
);

   logic [tpa_pkg::CNT_W-1:0] pending_ff;
   logic [tpa_pkg::CNT_W-1:0] pending_in;
   logic                      req_take;
   logic                      rsp_take;

   // Count items inside the block
   assign req_take   = req_tvalid && req_tready;
   assign rsp_take   = rsp_tvalid && rsp_tready;
   assign pending_in = pending_ff + tpa_pkg::CNT_W'(req_take) - tpa_pkg::CNT_W'(rsp_take);

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // A stalled result holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result item changed while stalled");

   // No result without an item inside
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> pending_ff != '0)
      else $error("result item with no item inside");

   // Never more items inside than stages
   a_depth: assert property (@(posedge clock) disable iff (reset)
      pending_ff <= tpa_pkg::CNT_W'(tpa_pkg::PIPE_DEPTH))
      else $error("more items inside than pipeline stages");

   // An empty output register lets the input side take an item
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input blocked while output register is empty");

   // Reset leaves no result pending
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

bind triangle_perimeter_area tpa_checker u_tpa_checker (.*);
